// ===== rtl/core/spq_pkg.sv =====
// Package for the sorted priority queue: item types, status codes and defaults.
// No dependencies; sorted_priority_queue imports it.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int PRIO_W        = 8;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 5;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        kind_t                    kind;
        logic [PRIO_W-1:0]        priority_req;
        logic signed [DATA_W-1:0] payload;
    } req_item_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] data_out;
        logic [OCC_W-1:0]         occupancy;
    } rsp_item_t;

    // One stored queue entry as it sits in the entry memory.
    typedef struct packed {
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

endpackage

// ===== rtl/core/spq_stream_if.sv =====
// Valid/ready channel carrying one item of a given type.
// Depends on spq_pkg only through the item types handed in as parameters.
interface spq_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/core/spq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted priority queue, minimum priority served first.
// Depends on spq_pkg, spq_stream_if and spq_ram.
//
// Usage:
//   req carries one item: kind (enqueue or dequeue), priority_req and payload.
//   rsp returns exactly one item per request: status, data_out, occupancy.
//   Both channels use valid/ready; an item moves when both are high.
//
// The entries live in one RAM, stored in descending priority so that the
// smallest priority sits at address count-1. A dequeue reads that top
// entry and drops the count; the result passes through S_RDQ and S_DONE
// into the output register. An enqueue walks down from the top, one
// entry per cycle, moving every entry with a smaller priority up one
// address while the walk reads the next one; the new entry lands in the
// gap. The walk streams through the single RAM read port. Overflow and
// underflow go straight to S_DONE and leave the RAM untouched.
//
// Reset clears the entry count and the output valid; RAM contents need no
// clearing since only entries below the count are ever read.
// A stalled receiver holds the result in the output register; one new
// request is still taken and processed, then waits until that slot frees.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    spq_stream_if.sink   req,
    spq_stream_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_INS  = 5'b00100,
        S_RDQ  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       j_reg, j_next;
    entry_t              new_reg, new_next;
    status_t             res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] res_data_reg, res_data_next;
    logic                out_valid_reg, out_valid_next;
    rsp_item_t           out_item_reg, out_item_next;

    logic                we, re;
    logic [AW-1:0]       waddr, raddr;
    entry_t              wdata, rdata;
    logic                load_out;

    spq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        j_next          = j_reg;
        new_next        = new_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        we              = 1'b0;
        waddr           = '0;
        wdata           = new_reg;
        re              = 1'b0;
        raddr           = '0;
        load_out        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = ST_DONE;
                    res_data_next   = '0;
                    if (req.item.kind == KIND_ENQ)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            // Full: drop the item.
                            res_status_next = ST_OVERFLOW;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            count_next    = CW'(count_reg + CW'(1));
                            new_next.prio = req.item.priority_req;
                            new_next.data = req.item.payload;
                            if (count_reg == '0)
                            begin
                                state_next = S_INS;
                            end
                            else
                            begin
                                // Start the walk at the smallest entry.
                                re         = 1'b1;
                                raddr      = AW'(count_reg - CW'(1));
                                j_next     = AW'(count_reg - CW'(1));
                                state_next = S_WALK;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_UNDERFLOW;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            count_next = CW'(count_reg - CW'(1));
                            re         = 1'b1;
                            raddr      = AW'(count_reg - CW'(1));
                            state_next = S_RDQ;
                        end
                    end
                end
            end

            S_WALK:
            begin
                // rdata holds the entry at j; the slot at j+1 is free.
                we    = 1'b1;
                waddr = AW'(j_reg + AW'(1));
                if (rdata.prio < new_reg.prio)
                begin
                    wdata = rdata;
                    if (j_reg == '0)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        re         = 1'b1;
                        raddr      = AW'(j_reg - AW'(1));
                        j_next     = AW'(j_reg - AW'(1));
                    end
                end
                else
                begin
                    wdata      = new_reg;
                    state_next = S_DONE;
                end
            end

            S_INS:
            begin
                // New entry has the largest priority: bottom of the store.
                we         = 1'b1;
                waddr      = '0;
                wdata      = new_reg;
                state_next = S_DONE;
            end

            S_RDQ:
            begin
                res_data_next = rdata.data;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_item_next = out_item_reg;
        if (load_out)
        begin
            out_valid_next          = 1'b1;
            out_item_next.status    = res_status_reg;
            out_item_next.data_out  = res_data_reg;
            out_item_next.occupancy = OCC_W'(count_reg);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        j_reg          <= j_next;
        new_reg        <= new_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        out_item_reg   <= out_item_next;
    end

endmodule
